// ===== rtl/sckal_pkg.sv =====
// ---------------------------------------------------------------------------
// sckal_pkg
// Shared types, constants and field helpers for the six channel scalar
// Kalman smoother.
// ---------------------------------------------------------------------------
package sckal_pkg;

  localparam int NUM_SENSORS  = 6;
  localparam int CHANNELS_DEF = 6;
  localparam int GAIN_FRAC_DEF = 16;

  localparam int EST_W      = 32;   // Q23.8 estimate
  localparam int VAR_W      = 32;   // unsigned Q16.16 variance
  localparam int EST_FRAC   = 8;
  localparam int VAR_FRAC   = 16;
  localparam int NOISE_W    = 16;
  localparam int INIT_EST_W = 24;
  localparam int INIT_VAR_W = 16;
  localparam int GYRO_W     = 24;
  localparam int ACCEL_W    = 16;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 24;
  localparam int IN_DW  = 3 * GYRO_W + 3 * ACCEL_W;
  localparam int OUT_DW = NUM_SENSORS * EST_W;
  localparam int SEN_W  = 3;

  // register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_NOISE_GX = 3'd0,
    REG_NOISE_GY = 3'd1,
    REG_NOISE_GZ = 3'd2,
    REG_NOISE_AX = 3'd3,
    REG_NOISE_AY = 3'd4,
    REG_NOISE_AZ = 3'd5,
    REG_INIT_EST = 3'd6,
    REG_INIT_VAR = 3'd7
  } cfg_reg_t;

  // sensor slots
  localparam logic [SEN_W-1:0] SEN_GX = 3'd0;
  localparam logic [SEN_W-1:0] SEN_GY = 3'd1;
  localparam logic [SEN_W-1:0] SEN_GZ = 3'd2;
  localparam logic [SEN_W-1:0] SEN_AX = 3'd3;
  localparam logic [SEN_W-1:0] SEN_AY = 3'd4;
  localparam logic [SEN_W-1:0] SEN_AZ = 3'd5;

  localparam logic [NOISE_W-1:0]    NOISE_RST     = 16'd25;
  localparam logic [NOISE_W-1:0]    NOISE_AZ_RST  = 16'd125;
  localparam logic [INIT_EST_W-1:0] INIT_EST_RST  = 24'd500;
  localparam logic [INIT_VAR_W-1:0] INIT_VAR_RST  = 16'd255;

  typedef struct packed {
    logic [EST_W-1:0] est;
    logic [VAR_W-1:0] var_q;
  } mem_word_t;

  // control group from sequencer to state memory
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } kal_ctl_t;

  function automatic mem_word_t init_word(input logic [INIT_EST_W-1:0] e,
                                          input logic [INIT_VAR_W-1:0] v);
    mem_word_t w;
    w.est   = {e, {EST_FRAC{1'b0}}};
    w.var_q = {v, {VAR_FRAC{1'b0}}};
    return w;
  endfunction

  // sample of one sensor slot as Q23.8
  function automatic logic [EST_W-1:0] sample_q(input logic [IN_DW-1:0] d,
                                                input logic [SEN_W-1:0] s);
    logic [EST_W-1:0] r;
    case (s)
      SEN_GX:  r = {d[23:0], 8'b0};
      SEN_GY:  r = {d[47:24], 8'b0};
      SEN_GZ:  r = {d[71:48], 8'b0};
      SEN_AX:  r = {{8{d[87]}}, d[87:72], 8'b0};
      SEN_AY:  r = {{8{d[103]}}, d[103:88], 8'b0};
      SEN_AZ:  r = {{8{d[119]}}, d[119:104], 8'b0};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/sckal_mem.sv =====
// ---------------------------------------------------------------------------
// sckal_mem
// Per-channel state store: estimate and variance in one synchronous RAM
// with a registered read port, with per-entry valid bits. An entry not yet
// written since the last restart reads as the restart snapshot.
// ---------------------------------------------------------------------------
module sckal_mem #(
  parameter int CHANNELS = 6,
  parameter int AW       = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sckal_pkg::kal_ctl_t  ctl,
  input  logic [AW-1:0]        addr,
  input  sckal_pkg::mem_word_t wr_data,
  input  sckal_pkg::mem_word_t init,
  output sckal_pkg::mem_word_t rd_data
);
  import sckal_pkg::*;

  mem_word_t             ram_r [CHANNELS];
  mem_word_t             rd_q_r;
  logic                  rd_vld_r;
  logic [CHANNELS-1:0]   vld_r;
  mem_word_t             snap_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      ram_r[addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q_r <= ram_r[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      snap_r   <= init_word(INIT_EST_RST, INIT_VAR_RST);
    end else begin
      if (ctl.clr) begin
        vld_r  <= '0;
        snap_r <= init;
      end else if (ctl.wr_en) begin
        vld_r[addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= vld_r[addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : snap_r;

endmodule

// ===== rtl/sckal_div.sv =====
// ---------------------------------------------------------------------------
// sckal_div
// Gain divider: floor(var * 2^G / den), restoring, one quotient bit per
// cycle. Zero divisor gives zero gain.
// ---------------------------------------------------------------------------
module sckal_div #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sckal_pkg::VAR_W-1:0]   var_in,
  input  logic [sckal_pkg::VAR_W:0]     den_in,
  output logic                          done,
  output logic [GAIN_FRAC_BITS:0]       gain
);
  import sckal_pkg::*;

  localparam int GW = GAIN_FRAC_BITS + 1;
  localparam int CW = $clog2(GW);

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [VAR_W:0]  rem_r;
  logic [VAR_W:0]  den_r;
  logic            dz_r;
  logic [GW-1:0]   q_r;
  logic [VAR_W+1:0] trial;
  logic            fits;
  logic [VAR_W:0]  rem_nxt;

  // the quotient register also holds the low dividend bits still to shift in
  always_comb begin
    trial   = {rem_r, q_r[GW-1]};
    fits    = trial >= {1'b0, den_r};
    rem_nxt = fits ? (VAR_W+1)'(trial - {1'b0, den_r}) : trial[VAR_W:0];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, var_in[VAR_W-1:1]};
      q_r   <= {var_in[0], {GAIN_FRAC_BITS{1'b0}}};
      den_r <= den_in;
      dz_r  <= (den_in == '0);
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[GW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(GAIN_FRAC_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign gain = dz_r ? '0 : q_r;

endmodule

// ===== rtl/sckal_upd.sv =====
// ---------------------------------------------------------------------------
// sckal_upd
// Estimate and variance update, three stages: difference and magnitude,
// the two products, then scale, sign and clamp.
// ---------------------------------------------------------------------------
module sckal_upd #(
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [GAIN_FRAC_BITS:0]       gain,
  input  logic [sckal_pkg::EST_W-1:0]   sample,
  input  sckal_pkg::mem_word_t          cur,
  output logic                          done,
  output sckal_pkg::mem_word_t          upd
);
  import sckal_pkg::*;

  localparam int GW = GAIN_FRAC_BITS + 1;
  localparam int MW = EST_W + 1;

  logic [2:0]          v_r;
  // stage 1
  logic [MW-1:0]       mag_r;
  logic                neg1_r;
  logic [GW-1:0]       gain1_r;
  logic [GW-1:0]       om1_r;
  mem_word_t           cur1_r;
  // stage 2
  logic [GW+MW-1:0]    pc_r;
  logic [GW+VAR_W-1:0] pv_r;
  logic                neg2_r;
  logic [EST_W-1:0]    est2_r;
  // stage 3
  mem_word_t           upd_r;

  logic [MW-1:0]       diff;
  logic [EST_W+1:0]    corr;
  logic signed [EST_W+1:0] sum;

  always_comb begin
    diff = {sample[EST_W-1], sample} - {cur.est[EST_W-1], cur.est};
    corr = pc_r[GAIN_FRAC_BITS +: EST_W+2];
    if (neg2_r) begin
      sum = $signed({{2{est2_r[EST_W-1]}}, est2_r}) - $signed(corr);
    end else begin
      sum = $signed({{2{est2_r[EST_W-1]}}, est2_r}) + $signed(corr);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg1_r  <= diff[MW-1];
      mag_r   <= diff[MW-1] ? MW'(-diff) : diff;
      gain1_r <= gain;
      om1_r   <= GW'(1 << GAIN_FRAC_BITS) - gain;
      cur1_r  <= cur;
    end
    if (v_r[0]) begin
      pc_r   <= gain1_r * mag_r;
      pv_r   <= cur1_r.var_q * om1_r;
      neg2_r <= neg1_r;
      est2_r <= cur1_r.est;
    end
    if (v_r[1]) begin
      if (sum > $signed(34'sh0_7FFF_FFFF)) begin
        upd_r.est <= 32'h7FFF_FFFF;
      end else if (sum < $signed(-34'sh0_8000_0000)) begin
        upd_r.est <= 32'h8000_0000;
      end else begin
        upd_r.est <= sum[EST_W-1:0];
      end
      upd_r.var_q <= pv_r[GAIN_FRAC_BITS +: VAR_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[1:0], start};
    end
  end

  assign done = v_r[2];
  assign upd  = upd_r;

endmodule

// ===== rtl/six_channel_scalar_kalman.sv =====
// Measure transfer: channels go one after another through the one-bit-per-cycle
//   gain divider. One item in flight; the next is taken while the previous result
//   waits.
// Synchronous active-low reset: registers to reset values, state reads as initial values.
// ---------------------------------------------------------------------------
// six_channel_scalar_kalman
// Six scalar Kalman smoothers over gyro and accelerometer samples, state
// held in a shared RAM and updated channel by channel.
// ---------------------------------------------------------------------------
module six_channel_scalar_kalman #(
  parameter int CHANNELS       = sckal_pkg::CHANNELS_DEF,
  parameter int GAIN_FRAC_BITS = sckal_pkg::GAIN_FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sckal_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [sckal_pkg::CFG_DW-1:0]  cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z
  input  logic [sckal_pkg::IN_DW-1:0]   in_tdata,
  // func
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // est_gyro_x, est_gyro_y, est_gyro_z, est_accel_x, est_accel_y, est_accel_z
  output logic [sckal_pkg::OUT_DW-1:0]  out_tdata
);
  import sckal_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int GW = GAIN_FRAC_BITS + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_DIVGO = 6'b000100,
    S_DIVW  = 6'b001000,
    S_UPDW  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [NOISE_W-1:0]     noise_r [NUM_SENSORS];
  logic [INIT_EST_W-1:0]  init_est_r;
  logic [INIT_VAR_W-1:0]  init_var_r;
  logic [IN_DW-1:0]       in_data_r;
  logic [AW-1:0]          ch_r;
  logic [SEN_W-1:0]       sens_r;
  mem_word_t              cur_r;
  logic [EST_W-1:0]       coll_r [NUM_SENSORS];
  logic                   out_tvalid_r;
  logic [OUT_DW-1:0]      out_tdata_r;

  kal_ctl_t               ctl;
  mem_word_t              rd_data;
  mem_word_t              upd;
  logic                   div_done, upd_done;
  logic [GW-1:0]          gain;
  logic [VAR_W:0]         den;
  logic                   in_acc, out_free, last_ch;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign last_ch   = (ch_r == AW'(CHANNELS - 1));
  assign den       = {1'b0, rd_data.var_q} + {1'b0, noise_r[sens_r], {VAR_FRAC{1'b0}}};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SENSORS - 1; i++) begin
        noise_r[i] <= NOISE_RST;
      end
      noise_r[NUM_SENSORS-1] <= NOISE_AZ_RST;
      init_est_r <= INIT_EST_RST;
      init_var_r <= INIT_VAR_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_NOISE_GX, REG_NOISE_GY, REG_NOISE_GZ,
        REG_NOISE_AX, REG_NOISE_AY, REG_NOISE_AZ: begin
          noise_r[cfg_addr] <= cfg_wdata[NOISE_W-1:0];
        end
        REG_INIT_EST: init_est_r <= cfg_wdata[INIT_EST_W-1:0];
        REG_INIT_VAR: init_var_r <= cfg_wdata[INIT_VAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            ctl.clr   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        ctl.rd_en = 1'b1;
        state_nxt = S_DIVGO;
      end
      S_DIVGO: state_nxt = S_DIVW;
      S_DIVW: begin
        if (div_done) begin
          state_nxt = S_UPDW;
        end
      end
      S_UPDW: begin
        if (upd_done) begin
          ctl.wr_en = 1'b1;
          state_nxt = last_ch ? S_DONE : S_READ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ch_r         <= '0;
      sens_r       <= SEN_GX;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        ch_r   <= '0;
        sens_r <= SEN_GX;
      end else if (state_r == S_UPDW && upd_done && !last_ch) begin
        ch_r   <= ch_r + 1'b1;
        sens_r <= (sens_r == SEN_AZ) ? SEN_GX : sens_r + 1'b1;
      end
      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_data_r <= in_tdata;
    end
    if (state_r == S_DIVGO) begin
      cur_r <= rd_data;
    end
    if (ctl.clr) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        coll_r[i] <= {init_est_r, {EST_FRAC{1'b0}}};
      end
    end else if (ctl.wr_en) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        if (int'(ch_r) == i) begin
          coll_r[i] <= upd.est;
        end
      end
    end
    if (state_r == S_DONE && out_free) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        out_tdata_r[i*EST_W +: EST_W] <= (i < CHANNELS) ? coll_r[i] : '0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  sckal_mem #(
    .CHANNELS (CHANNELS),
    .AW       (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .addr    (ch_r),
    .wr_data (upd),
    .init    (init_word(init_est_r, init_var_r)),
    .rd_data (rd_data)
  );

  sckal_div #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_DIVGO),
    .var_in (rd_data.var_q),
    .den_in (den),
    .done   (div_done),
    .gain   (gain)
  );

  sckal_upd #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_upd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (state_r == S_DIVW && div_done),
    .gain   (gain),
    .sample (sample_q(in_data_r, sens_r)),
    .cur    (cur_r),
    .done   (upd_done),
    .upd    (upd)
  );

`ifndef SYNTH
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIVW)
    else $error("divider finished outside its wait state");

  a_upd_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    upd_done |-> state_r == S_UPDW)
    else $error("update finished outside its wait state");

  a_sens_range: assert property (@(posedge clk) disable iff (!rst_n)
    sens_r <= SEN_AZ)
    else $error("sensor slot out of range");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_tvalid_r && !out_tready) |=> state_r == S_DONE)
    else $error("result dropped while output register full");
`endif

endmodule

// ===== tb/sv/sckal_tb_pkg.sv =====
// ---------------------------------------------------------------------------
// sckal_tb_pkg
// Item kind codes shared by the stimulus and the checker of the six channel
// scalar Kalman smoother testbench.
// ---------------------------------------------------------------------------
package sckal_tb_pkg;

  // carried on in_tuser
  typedef enum logic {
    FUNC_MEASURE = 1'b0,
    FUNC_RESTART = 1'b1
  } kal_func_t;

endpackage

// ===== tb/sv/sckal_checker.sv =====
// ---------------------------------------------------------------------------
// sckal_checker
// Passive checker: follows register writes, predicts the six estimates for
// every input transfer and compares each output transfer against the oldest
// prediction.
// ---------------------------------------------------------------------------
module sckal_checker #(
  parameter int CHANNELS       = sckal_pkg::CHANNELS_DEF,
  parameter int GAIN_FRAC_BITS = sckal_pkg::GAIN_FRAC_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [sckal_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [sckal_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [sckal_pkg::IN_DW-1:0]  in_tdata,
  input  logic                         in_tuser,
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [sckal_pkg::OUT_DW-1:0] out_tdata,
  output int                           mismatches,
  output int                           outstanding
);
  import sckal_pkg::*;
  import sckal_tb_pkg::*;

  localparam longint EST_MAX    = (longint'(1) <<< 31) - 1;
  localparam longint EST_MIN    = -(longint'(1) <<< 31);
  localparam int     PRINT_CAP  = 100;

  logic [NOISE_W-1:0]    noise_reg [NUM_SENSORS];
  logic [INIT_EST_W-1:0] init_est_reg;
  logic [INIT_VAR_W-1:0] init_var_reg;
  longint                est_q [CHANNELS];
  longint unsigned       var_q [CHANNELS];

  logic [OUT_DW-1:0]     estimates_due [$];
  logic [OUT_DW-1:0]     predicted;
  logic [OUT_DW-1:0]     want;
  int                    errors = 0;
  int                    results_seen = 0;

  string field_name [NUM_SENSORS] = '{"est_gyro_x", "est_gyro_y", "est_gyro_z",
                                      "est_accel_x", "est_accel_y", "est_accel_z"};

  task automatic report_mismatch(input string what, input logic [EST_W-1:0] got,
                                 input logic [EST_W-1:0] exp_val);
    errors++;
    if (errors <= PRINT_CAP)
      $display("[%0t] mismatch on %s at result %0d: got %h, expected %h",
               $time, what, results_seen, got, exp_val);
  endtask

  task automatic reload_filters();
    longint e;
    e = longint'($signed(init_est_reg)) * 256;
    for (int i = 0; i < CHANNELS; i++) begin
      est_q[i] = e;
      var_q[i] = longint'(init_var_reg) << VAR_FRAC;
    end
  endtask

  task automatic restore_defaults();
    for (int i = 0; i < NUM_SENSORS; i++)
      noise_reg[i] = NOISE_RST;
    noise_reg[SEN_AZ] = NOISE_AZ_RST;
    init_est_reg = INIT_EST_RST;
    init_var_reg = INIT_VAR_RST;
    reload_filters();
  endtask

  task automatic store_register(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    case (cfg_reg_t'(addr))
      REG_NOISE_GX, REG_NOISE_GY, REG_NOISE_GZ,
      REG_NOISE_AX, REG_NOISE_AY, REG_NOISE_AZ: noise_reg[addr] = data[NOISE_W-1:0];
      REG_INIT_EST: init_est_reg = data[INIT_EST_W-1:0];
      REG_INIT_VAR: init_var_reg = data[INIT_VAR_W-1:0];
      default: ;
    endcase
  endtask

  function automatic longint sample_of(input logic [IN_DW-1:0] d, input int s);
    longint v;
    case (s)
      SEN_GX:  v = $signed(d[0 * GYRO_W +: GYRO_W]);
      SEN_GY:  v = $signed(d[1 * GYRO_W +: GYRO_W]);
      SEN_GZ:  v = $signed(d[2 * GYRO_W +: GYRO_W]);
      SEN_AX:  v = $signed(d[3 * GYRO_W + 0 * ACCEL_W +: ACCEL_W]);
      SEN_AY:  v = $signed(d[3 * GYRO_W + 1 * ACCEL_W +: ACCEL_W]);
      SEN_AZ:  v = $signed(d[3 * GYRO_W + 2 * ACCEL_W +: ACCEL_W]);
      default: v = 0;
    endcase
    return v;
  endfunction

  // one scalar update; a zero divisor leaves the gain at zero
  task automatic smooth_channel(input int ch, input longint smp, input logic [NOISE_W-1:0] nz);
    longint unsigned v, den, gain, mag, corr, unity;
    longint          diff, e;
    v     = var_q[ch];
    unity = longint'(1) << GAIN_FRAC_BITS;
    den   = v + (longint'(nz) << VAR_FRAC);
    gain  = (den != 0) ? (v << GAIN_FRAC_BITS) / den : 0;
    diff  = smp * 256 - est_q[ch];
    mag   = (diff < 0) ? longint'(-diff) : longint'(diff);
    corr  = (gain * mag) >> GAIN_FRAC_BITS;
    e     = (diff < 0) ? est_q[ch] - longint'(corr) : est_q[ch] + longint'(corr);
    if (e > EST_MAX)
      e = EST_MAX;
    if (e < EST_MIN)
      e = EST_MIN;
    est_q[ch] = e;
    var_q[ch] = (v * (unity - gain)) >> GAIN_FRAC_BITS;
  endtask

  task automatic advance_filters(input logic func, input logic [IN_DW-1:0] d,
                                 output logic [OUT_DW-1:0] res);
    int s;
    res = '0;
    if (func == FUNC_RESTART) begin
      reload_filters();
    end else begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        s = ch % NUM_SENSORS;
        smooth_channel(ch, sample_of(d, s), noise_reg[s]);
      end
    end
    for (int ch = 0; ch < CHANNELS && ch < NUM_SENSORS; ch++)
      res[ch * EST_W +: EST_W] = est_q[ch][EST_W-1:0];
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      restore_defaults();
      estimates_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (estimates_due.size() == 0) begin
          report_mismatch("result with nothing expected", out_tdata[EST_W-1:0], '0);
        end else begin
          want = estimates_due.pop_front();
          for (int f = 0; f < NUM_SENSORS; f++)
            if (out_tdata[f * EST_W +: EST_W] !== want[f * EST_W +: EST_W])
              report_mismatch(field_name[f], out_tdata[f * EST_W +: EST_W],
                              want[f * EST_W +: EST_W]);
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        advance_filters(in_tuser, in_tdata, predicted);
        estimates_due.push_back(predicted);
      end
      // a write lands after any transfer at the same edge
      if (cfg_we)
        store_register(cfg_addr, cfg_wdata);
    end
    outstanding <= estimates_due.size();
    mismatches  <= errors;
  end

endmodule

// ===== tb/sv/six_channel_scalar_kalman_test.sv =====
// ---------------------------------------------------------------------------
// six_channel_scalar_kalman_test
// Stimulus and verdict for the six channel scalar Kalman smoother: directed
// extremes and zero-noise cases, then randomised phases under changing
// register settings with stalls on both streams and one long output hold-off.
// ---------------------------------------------------------------------------
module six_channel_scalar_kalman_test;
  import sckal_pkg::*;
  import sckal_tb_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int SQUEEZE_PHASE   = 2;
  localparam int SQUEEZE_CYCLES  = 800;
  localparam int DRAIN_CYCLES    = 300;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              cfg_we     = 1'b0;
  logic [CFG_AW-1:0] cfg_addr   = '0;
  logic [CFG_DW-1:0] cfg_wdata  = '0;
  logic              in_tvalid  = 1'b0;
  logic [IN_DW-1:0]  in_tdata   = '0;
  logic              in_tuser   = 1'b0;
  logic              out_tready = 1'b0;
  logic              in_tready;
  logic              out_tvalid;
  logic [OUT_DW-1:0] out_tdata;

  int mismatches;
  int outstanding;
  int items_sent    = 0;
  int restarts_sent = 0;
  int settings_used = 0;
  int cycles        = 0;
  bit idling        = 1'b1;
  bit squeeze_req   = 1'b0;
  bit squeeze_done  = 1'b0;

  six_channel_scalar_kalman u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sckal_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timed out after %0d cycles, %0d results still due", cycles, outstanding);
    $display("six_channel_scalar_kalman_test NOT OK");
    $finish;
  end

  // --- value pickers -------------------------------------------------------

  function automatic logic [IN_DW-1:0] pack_samples(
    input logic [GYRO_W-1:0] gx, input logic [GYRO_W-1:0] gy, input logic [GYRO_W-1:0] gz,
    input logic [ACCEL_W-1:0] ax, input logic [ACCEL_W-1:0] ay, input logic [ACCEL_W-1:0] az);
    return {az, ay, ax, gz, gy, gx};
  endfunction

  function automatic logic [23:0] near_zero(input int span);
    return 24'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [23:0] extreme_value(input int w);
    case ($urandom_range(0, 3))
      0:       return 24'((1 << (w - 1)) - 1);
      1:       return 24'(1 << (w - 1));
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [IN_DW-1:0] random_samples();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 3))
      1: return pack_samples(near_zero(1000), near_zero(1000), near_zero(1000),
                             ACCEL_W'(near_zero(300)), ACCEL_W'(near_zero(300)),
                             ACCEL_W'(near_zero(300)));
      2: return pack_samples(extreme_value(GYRO_W), extreme_value(GYRO_W),
                             extreme_value(GYRO_W), ACCEL_W'(extreme_value(ACCEL_W)),
                             ACCEL_W'(extreme_value(ACCEL_W)),
                             ACCEL_W'(extreme_value(ACCEL_W)));
      default: return raw[IN_DW-1:0];
    endcase
  endfunction

  function automatic logic [NOISE_W-1:0] pick_noise();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return NOISE_W'(1);
      2:       return '1;
      3, 4:    return NOISE_W'($urandom_range(1, 64));
      default: return NOISE_W'($urandom);
    endcase
  endfunction

  function automatic logic [NUM_SENSORS*NOISE_W-1:0] random_noise_set();
    logic [NUM_SENSORS*NOISE_W-1:0] nz;
    for (int i = 0; i < NUM_SENSORS; i++)
      nz[i * NOISE_W +: NOISE_W] = pick_noise();
    return nz;
  endfunction

  function automatic logic [INIT_EST_W-1:0] pick_init_est();
    case ($urandom_range(0, 4))
      0:       return 24'h7FFFFF;
      1:       return 24'h800000;
      2, 3:    return near_zero(1000);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [INIT_VAR_W-1:0] pick_init_var();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return INIT_VAR_W'(1);
      2:       return '1;
      3, 4:    return INIT_VAR_W'($urandom_range(1, 300));
      default: return INIT_VAR_W'($urandom);
    endcase
  endfunction

  // --- bus tasks -----------------------------------------------------------

  // all eight registers; unused upper data bits carry noise
  task automatic program_regs(input logic [NUM_SENSORS*NOISE_W-1:0] nz,
                              input logic [INIT_EST_W-1:0] ie,
                              input logic [INIT_VAR_W-1:0] iv);
    for (int i = 0; i < NUM_SENSORS; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_AW'(REG_NOISE_GX) + CFG_AW'(i);
      cfg_wdata <= {8'($urandom), nz[i * NOISE_W +: NOISE_W]};
      @(posedge clk);
    end
    cfg_addr  <= REG_INIT_EST;
    cfg_wdata <= ie;
    @(posedge clk);
    cfg_addr  <= REG_INIT_VAR;
    cfg_wdata <= {8'($urandom), iv};
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // tvalid stays up between back-to-back transfers
  task automatic send_item(input kal_func_t f, input logic [IN_DW-1:0] d);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (f == FUNC_RESTART)
      restarts_sent++;
  endtask

  // outstanding is registered in the checker, so it lags the transfers
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : sink
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze_req && !squeeze_done) begin
        out_tready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
      end else if (idling && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    kal_func_t f;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values first
    send_item(FUNC_MEASURE, '0);
    send_item(FUNC_MEASURE, pack_samples(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                                         16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_item(FUNC_MEASURE, pack_samples(24'h800000, 24'h800000, 24'h800000,
                                         16'h8000, 16'h8000, 16'h8000));
    send_item(FUNC_MEASURE, pack_samples(24'h7FFFFF, 24'h800000, 24'hFFFFFF,
                                         16'h8000, 16'h7FFF, 16'hFFFF));
    send_item(FUNC_RESTART, random_samples());
    send_item(FUNC_MEASURE, random_samples());
    wait_idle();

    // zero noise on the gyros and accel z: gain of one, then a zero divisor
    program_regs({16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'd0}, 24'h7FFFFF, 16'hFFFF);
    send_item(FUNC_RESTART, '0);
    send_item(FUNC_MEASURE, pack_samples(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                                         16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_item(FUNC_MEASURE, pack_samples(24'h800000, 24'h800000, 24'h800000,
                                         16'h8000, 16'h8000, 16'h8000));
    send_item(FUNC_MEASURE, '0);
    send_item(FUNC_RESTART, random_samples());
    send_item(FUNC_MEASURE, pack_samples(24'h800000, 24'h800000, 24'h800000,
                                         16'h8000, 16'h8000, 16'h8000));
    wait_idle();

    // zero noise with zero initial variance everywhere
    program_regs('0, 24'h800000, 16'd0);
    send_item(FUNC_RESTART, '1);
    send_item(FUNC_MEASURE, pack_samples(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                                         16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_item(FUNC_MEASURE, random_samples());
    wait_idle();

    // largest noise, smallest non-zero variance
    program_regs('1, 24'd0, 16'd1);
    send_item(FUNC_RESTART, '0);
    send_item(FUNC_MEASURE, pack_samples(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                                         16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_item(FUNC_MEASURE, pack_samples(24'h800000, 24'h800000, 24'h800000,
                                         16'h8000, 16'h8000, 16'h8000));
    send_item(FUNC_MEASURE, random_samples());
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_regs(random_noise_set(), pick_init_est(), pick_init_var());
      idling = (p < RANDOM_PHASES - 2) && (p % 3 != 1);
      if (p == SQUEEZE_PHASE)
        squeeze_req = 1'b1;
      send_item(FUNC_RESTART, random_samples());
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        f = FUNC_MEASURE;
        if ($urandom_range(0, 9) == 0)
          f = FUNC_RESTART;
        send_item(f, random_samples());
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d items (%0d restarts) over %0d register settings in %0d cycles",
             items_sent, restarts_sent, settings_used, cycles);
    $display("output held off once for %0d cycles with input still offered", SQUEEZE_CYCLES);
    if (mismatches == 0 && outstanding == 0)
      $display("six_channel_scalar_kalman_test OK");
    else
      $display("six_channel_scalar_kalman_test NOT OK");
    $finish;
  end

endmodule
